### rtl/core/mpdc_pkg.sv
package mpdc_pkg;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_MASK  = 1'b1;

    localparam logic [2:0] CFG_WIDTH      = 3'd0;
    localparam logic [2:0] CFG_HEIGHT     = 3'd1;
    localparam logic [2:0] CFG_REGION     = 3'd2;
    localparam logic [2:0] CFG_TOLERANCE  = 3'd3;
    localparam logic [2:0] CFG_SKIP_ALPHA = 3'd4;
    localparam logic [2:0] CFG_THRESHOLD  = 3'd5;

    localparam logic [31:0] BLACK_PIXEL = 32'hFF00_0000;
    localparam logic [31:0] CYAN_PIXEL  = 32'hFFFF_FF00;
    localparam logic [24:0] TALLY_MAX   = 25'h1FF_FFFF;
    localparam logic [14:0] FULL_PASS   = 15'd25600;
    localparam logic [12:0] SIZE_MAX    = 13'd4096;
    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic               operation;
        logic [31:0]        actual_pixel;
        logic [31:0]        baseline_pixel;
        logic [2:0]         mask_slot;
        logic signed [15:0] mask_x;
        logic signed [15:0] mask_y;
        logic signed [15:0] mask_w;
        logic signed [15:0] mask_h;
    } t_pix_in;

    typedef struct packed {
        logic [31:0] diff_pixel;
        logic        frame_end;
        logic [24:0] differing_count;
        logic [24:0] compared_count;
        logic [7:0]  peak_difference;
        logic        passed;
    } t_pix_out;

    typedef struct packed {
        logic signed [17:0] x0;
        logic signed [17:0] x1;
        logic signed [17:0] y0;
        logic signed [17:0] y1;
    } t_mask;

    typedef struct packed {
        logic       compared;
        logic       masked;
        logic [7:0] chan_peak;
        logic       last;
    } t_classify;

    typedef struct packed {
        t_pix_out    res;
        logic [39:0] lhs;
        logic [39:0] rhs;
        logic        total_zero;
    } t_verdict;

endpackage

### rtl/core/masked_pixel_diff_counter.sv
// Throughput: one transaction per cycle unless back-pressure on i_ready stalls the stages;
// a mask load takes one slot and gives no result.
// Five register stages: input, classify (region, masks, channel diff), tally, products, verdict.
// Reset (synchronous, active low): stages empty, position and tallies zero, masks off,
// configuration back to 640x480, whole-image region, tolerance 0, alpha used, threshold 0.
module masked_pixel_diff_counter #(
    parameter int MASKS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mpdc_pkg::t_pix_in  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mpdc_pkg::t_pix_out o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import mpdc_pkg::*;

    logic [12:0] r_width, r_height;
    logic [63:0] r_region;
    logic [7:0]  r_tolerance;
    logic        r_skip_alpha;
    logic [14:0] r_threshold;

    logic [11:0] r_col, r_row;
    logic [24:0] r_diff_tally, r_total_tally;
    logic [7:0]  r_peak_tally;

    t_mask            r_mask [MASKS];
    logic [MASKS-1:0] r_mask_en;

    logic      r_v1, r_v2, r_v3, r_v4, r_v5;
    t_pix_in   r_s1;
    t_classify r_s2;
    t_pix_out  r_s3;
    t_verdict  r_s4;
    t_pix_out  r_s5;

    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5         = r_v4 && (!r_v5 || i_ready);
    assign ld4         = r_v3 && (!r_v4 || ld5);
    assign ld3         = r_v2 && (!r_v3 || ld4);
    assign ld2         = r_v1 && (!r_v2 || ld3);
    assign o_ready     = !r_v1 || ld2;
    assign ld1         = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_v5;
    assign o_data      = r_s5;

    // Classify stage
    logic [12:0] wd, ht;
    logic signed [17:0] pxs, pys, rx, ry, rw, rh, rx0, rx1, ry0, ry1, rxe, rye, wds, hts;
    logic in_region, mask_hit, last;
    logic [11:0] n_col, n_row;
    logic [7:0] cd [4];
    logic [7:0] chan_peak;
    t_mask n_mask;
    logic  n_mask_en;
    t_classify n_s2;

    always_comb begin
        wd = (r_width == 13'd0) ? 13'd1 : ((r_width > SIZE_MAX) ? SIZE_MAX : r_width);
        ht = (r_height == 13'd0) ? 13'd1 : ((r_height > SIZE_MAX) ? SIZE_MAX : r_height);
        wds = {5'd0, wd};
        hts = {5'd0, ht};
        pxs = {6'd0, r_col};
        pys = {6'd0, r_row};
        rx  = {{2{r_region[15]}}, r_region[15:0]};
        ry  = {{2{r_region[31]}}, r_region[31:16]};
        rw  = {{2{r_region[47]}}, r_region[47:32]};
        rh  = {{2{r_region[63]}}, r_region[63:48]};
        rxe = rx + rw;
        rye = ry + rh;
        rx0 = (rx > 18'sd0) ? rx : 18'sd0;
        ry0 = (ry > 18'sd0) ? ry : 18'sd0;
        rx1 = (rxe < wds) ? rxe : wds;
        ry1 = (rye < hts) ? rye : hts;
        in_region = (rw <= 18'sd0) || (rh <= 18'sd0) || (rx1 <= rx0) || (ry1 <= ry0) ||
                    (pxs >= rx0 && pxs < rx1 && pys >= ry0 && pys < ry1);

        mask_hit = 1'b0;
        for (int i = 0; i < MASKS; i++) begin
            if (r_mask_en[i] && pxs >= r_mask[i].x0 && pxs < r_mask[i].x1 &&
                pys >= r_mask[i].y0 && pys < r_mask[i].y1) begin
                mask_hit = 1'b1;
            end
        end

        for (int c = 0; c < 4; c++) begin
            cd[c] = (r_s1.actual_pixel[c*8 +: 8] > r_s1.baseline_pixel[c*8 +: 8]) ?
                    r_s1.actual_pixel[c*8 +: 8] - r_s1.baseline_pixel[c*8 +: 8] :
                    r_s1.baseline_pixel[c*8 +: 8] - r_s1.actual_pixel[c*8 +: 8];
        end
        if (r_skip_alpha) begin
            cd[3] = 8'd0;
        end
        chan_peak = cd[0];
        for (int c = 1; c < 4; c++) begin
            if (cd[c] > chan_peak) begin
                chan_peak = cd[c];
            end
        end

        last  = 1'b0;
        n_col = r_col + 12'd1;
        n_row = r_row;
        if ({1'b0, r_col} >= wd - 13'd1) begin
            n_col = 12'd0;
            if ({1'b0, r_row} >= ht - 13'd1) begin
                n_row = 12'd0;
                last  = 1'b1;
            end else begin
                n_row = r_row + 12'd1;
            end
        end

        n_s2.compared  = in_region && !mask_hit;
        n_s2.masked    = in_region && mask_hit;
        n_s2.chan_peak = chan_peak;
        n_s2.last      = last;

        n_mask.x0 = {{2{r_s1.mask_x[15]}}, r_s1.mask_x};
        n_mask.y0 = {{2{r_s1.mask_y[15]}}, r_s1.mask_y};
        n_mask.x1 = n_mask.x0 + {{2{r_s1.mask_w[15]}}, r_s1.mask_w};
        n_mask.y1 = n_mask.y0 + {{2{r_s1.mask_h[15]}}, r_s1.mask_h};
        n_mask_en = (r_s1.mask_w > 16'sd0) && (r_s1.mask_h > 16'sd0);
    end

    // Tally stage
    logic        differs;
    logic [24:0] n_diff_tally, n_total_tally;
    logic [7:0]  n_peak_tally;
    t_pix_out    n_s3;

    always_comb begin
        differs       = r_s2.compared && (r_s2.chan_peak > r_tolerance);
        n_total_tally = r_total_tally;
        n_diff_tally  = r_diff_tally;
        n_peak_tally  = r_peak_tally;
        if (r_s2.compared && r_total_tally < TALLY_MAX) begin
            n_total_tally = r_total_tally + 25'd1;
        end
        if (differs) begin
            if (r_diff_tally < TALLY_MAX) begin
                n_diff_tally = r_diff_tally + 25'd1;
            end
            if (r_s2.chan_peak > r_peak_tally) begin
                n_peak_tally = r_s2.chan_peak;
            end
        end
        n_s3.diff_pixel = r_s2.masked ? CYAN_PIXEL :
                          (differs ? (BLACK_PIXEL | {24'd0, r_s2.chan_peak}) : BLACK_PIXEL);
        n_s3.frame_end       = r_s2.last;
        n_s3.differing_count = r_s2.last ? n_diff_tally : 25'd0;
        n_s3.compared_count  = r_s2.last ? n_total_tally : 25'd0;
        n_s3.peak_difference = r_s2.last ? n_peak_tally : 8'd0;
        n_s3.passed          = 1'b0;
    end

    // Product and verdict stages
    t_verdict n_s4;
    t_pix_out n_s5;

    always_comb begin
        n_s4.res        = r_s3;
        n_s4.lhs        = ({15'd0, r_s3.differing_count} << 14) +
                          ({15'd0, r_s3.differing_count} << 13) +
                          ({15'd0, r_s3.differing_count} << 10);
        n_s4.rhs        = {25'd0, r_threshold} * {15'd0, r_s3.compared_count};
        n_s4.total_zero = (r_s3.compared_count == 25'd0);

        n_s5 = r_s4.res;
        if (r_s4.res.frame_end) begin
            n_s5.passed = r_s4.total_zero ? (r_threshold >= FULL_PASS) : (r_s4.lhs <= r_s4.rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width       <= WIDTH_RESET;
            r_height      <= HEIGHT_RESET;
            r_region      <= 64'd0;
            r_tolerance   <= 8'd0;
            r_skip_alpha  <= 1'b0;
            r_threshold   <= 15'd0;
            r_col         <= 12'd0;
            r_row         <= 12'd0;
            r_diff_tally  <= 25'd0;
            r_total_tally <= 25'd0;
            r_peak_tally  <= 8'd0;
            r_mask_en     <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_v5          <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:      r_width      <= i_cfg_data[12:0];
                    CFG_HEIGHT:     r_height     <= i_cfg_data[12:0];
                    CFG_REGION:     r_region     <= i_cfg_data;
                    CFG_TOLERANCE:  r_tolerance  <= i_cfg_data[7:0];
                    CFG_SKIP_ALPHA: r_skip_alpha <= i_cfg_data[0];
                    CFG_THRESHOLD:  r_threshold  <= i_cfg_data[14:0];
                    default: ;
                endcase
            end

            if (ld1) begin
                r_v1 <= 1'b1;
            end else if (ld2) begin
                r_v1 <= 1'b0;
            end

            if (ld2) begin
                r_v2 <= (r_s1.operation == OP_PIXEL);
                if (r_s1.operation == OP_PIXEL) begin
                    r_col <= n_col;
                    r_row <= n_row;
                end else begin
                    for (int i = 0; i < MASKS; i++) begin
                        if (int'(r_s1.mask_slot) == i) begin
                            r_mask_en[i] <= n_mask_en;
                        end
                    end
                end
            end else if (ld3) begin
                r_v2 <= 1'b0;
            end

            if (ld3) begin
                r_v3 <= 1'b1;
                if (r_s2.last) begin
                    r_diff_tally  <= 25'd0;
                    r_total_tally <= 25'd0;
                    r_peak_tally  <= 8'd0;
                end else begin
                    r_diff_tally  <= n_diff_tally;
                    r_total_tally <= n_total_tally;
                    r_peak_tally  <= n_peak_tally;
                end
            end else if (ld4) begin
                r_v3 <= 1'b0;
            end

            if (ld4) begin
                r_v4 <= 1'b1;
            end else if (ld5) begin
                r_v4 <= 1'b0;
            end

            if (ld5) begin
                r_v5 <= 1'b1;
            end else if (i_ready) begin
                r_v5 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1 <= i_data;
        end
        if (ld2 && r_s1.operation == OP_MASK) begin
            for (int i = 0; i < MASKS; i++) begin
                if (int'(r_s1.mask_slot) == i) begin
                    r_mask[i] <= n_mask;
                end
            end
        end
        if (ld2) begin
            r_s2 <= n_s2;
        end
        if (ld3) begin
            r_s3 <= n_s3;
        end
        if (ld4) begin
            r_s4 <= n_s4;
        end
        if (ld5) begin
            r_s5 <= n_s5;
        end
    end

    a_diff_le_compared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.frame_end |-> o_data.differing_count <= o_data.compared_count)
        else $error("differing count above compared count");

    a_peak_needs_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.peak_difference != 8'd0 |-> o_data.differing_count != 25'd0)
        else $error("peak without differing pixels");

    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.frame_end |->
            o_data.compared_count == 25'd0 && !o_data.passed)
        else $error("summary outside frame end");

    a_opaque_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.diff_pixel[31:24] == 8'hFF)
        else $error("diff pixel not opaque");

    a_tally_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld3 && r_s2.last |=> r_total_tally == 25'd0 && r_diff_tally == 25'd0)
        else $error("tallies not cleared after frame end");

endmodule

### verif/diff_frame_checker.sv
`timescale 1ns / 1ps

module diff_frame_checker #(
    parameter int MASKS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mpdc_pkg::t_pix_in  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mpdc_pkg::t_pix_out i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_frames
);
    import mpdc_pkg::*;

    logic [12:0] width_q;
    logic [12:0] height_q;
    logic [63:0] region_q;
    logic [7:0]  tolerance_q;
    logic        skip_alpha_q;
    logic [14:0] threshold_q;
    logic [11:0] col_q;
    logic [11:0] row_q;
    logic [24:0] diff_tally;
    logic [24:0] seen_tally;
    logic [7:0]  peak_q;
    logic [63:0] mask_tab [MASKS];
    t_pix_out    expected_q [$];
    t_pix_out    want;
    int          mismatch_cnt = 0;
    int          frame_cnt = 0;

    function automatic int eff_dim(logic [12:0] v);
        if (v == '0) return 1;
        if (v > SIZE_MAX) return int'(SIZE_MAX);
        return int'(v);
    endfunction

    // Classifies one pixel at the tracked position and advances the frame state.
    function automatic t_pix_out grade_pixel(t_pix_in it);
        t_pix_out    res;
        int          wd, ht, px, py, x0, y0, x1, y1, rx, ry, rw, rh, c;
        logic        in_area, masked;
        logic [7:0]  gap, worst, ca, cb;
        logic [63:0] lhs, rhs;
        wd = eff_dim(width_q);
        ht = eff_dim(height_q);
        px = col_q;
        py = row_q;
        res = '0;
        res.diff_pixel = BLACK_PIXEL;

        rx = $signed(region_q[15:0]);
        ry = $signed(region_q[31:16]);
        rw = $signed(region_q[47:32]);
        rh = $signed(region_q[63:48]);
        in_area = 1'b1;
        if (rw > 0 && rh > 0) begin
            x0 = (rx > 0) ? rx : 0;
            y0 = (ry > 0) ? ry : 0;
            x1 = (rx + rw < wd) ? rx + rw : wd;
            y1 = (ry + rh < ht) ? ry + rh : ht;
            // a region clamped to nothing falls back to the whole image
            if (x1 > x0 && y1 > y0) begin
                in_area = px >= x0 && px < x1 && py >= y0 && py < y1;
            end
        end

        if (in_area) begin
            masked = 1'b0;
            for (c = 0; c < MASKS; c++) begin
                rx = $signed(mask_tab[c][15:0]);
                ry = $signed(mask_tab[c][31:16]);
                rw = $signed(mask_tab[c][47:32]);
                rh = $signed(mask_tab[c][63:48]);
                if (rw > 0 && rh > 0 && px >= rx && px < rx + rw && py >= ry && py < ry + rh) begin
                    masked = 1'b1;
                end
            end
            if (masked) begin
                res.diff_pixel = CYAN_PIXEL;
            end else begin
                worst = '0;
                for (c = 0; c < 4; c++) begin
                    ca = it.actual_pixel[8*c +: 8];
                    cb = it.baseline_pixel[8*c +: 8];
                    gap = (ca > cb) ? ca - cb : cb - ca;
                    if ((c < 3 || !skip_alpha_q) && gap > worst) worst = gap;
                end
                if (seen_tally != TALLY_MAX) seen_tally++;
                if (worst > tolerance_q) begin
                    if (diff_tally != TALLY_MAX) diff_tally++;
                    if (worst > peak_q) peak_q = worst;
                    res.diff_pixel = BLACK_PIXEL | 32'(worst);
                end
            end
        end

        if (px >= wd - 1) begin
            col_q = '0;
            if (py >= ht - 1) begin
                row_q = '0;
                res.frame_end = 1'b1;
            end else begin
                row_q++;
            end
        end else begin
            col_q++;
        end

        if (res.frame_end) begin
            lhs = 64'(diff_tally) * 64'(FULL_PASS);
            rhs = 64'(threshold_q) * 64'(seen_tally);
            res.differing_count = diff_tally;
            res.compared_count  = seen_tally;
            res.peak_difference = peak_q;
            res.passed = (seen_tally == '0) ? (threshold_q >= FULL_PASS) : (lhs <= rhs);
            diff_tally = '0;
            seen_tally = '0;
            peak_q     = '0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] wanted);
        mismatch_cnt++;
        if (mismatch_cnt <= 40) begin
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, wanted);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_q      = WIDTH_RESET;
            height_q     = HEIGHT_RESET;
            region_q     = '0;
            tolerance_q  = '0;
            skip_alpha_q = 1'b0;
            threshold_q  = '0;
            col_q        = '0;
            row_q        = '0;
            diff_tally   = '0;
            seen_tally   = '0;
            peak_q       = '0;
            foreach (mask_tab[k]) mask_tab[k] = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:      width_q = i_cfg_data[12:0];
                    CFG_HEIGHT:     height_q = i_cfg_data[12:0];
                    CFG_REGION:     region_q = i_cfg_data;
                    CFG_TOLERANCE:  tolerance_q = i_cfg_data[7:0];
                    CFG_SKIP_ALPHA: skip_alpha_q = i_cfg_data[0];
                    CFG_THRESHOLD:  threshold_q = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.operation == OP_MASK) begin
                    if (i_in_data.mask_slot < MASKS) begin
                        mask_tab[i_in_data.mask_slot] = {i_in_data.mask_h, i_in_data.mask_w,
                                                         i_in_data.mask_y, i_in_data.mask_x};
                    end
                end else begin
                    expected_q = {expected_q, grade_pixel(i_in_data)};
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with nothing expected", i_out_data.diff_pixel, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (want.frame_end) frame_cnt++;
                    if (i_out_data.diff_pixel !== want.diff_pixel)
                        report_mismatch("diff_pixel", i_out_data.diff_pixel, want.diff_pixel);
                    if (i_out_data.frame_end !== want.frame_end)
                        report_mismatch("frame_end", 32'(i_out_data.frame_end),
                                        32'(want.frame_end));
                    if (i_out_data.differing_count !== want.differing_count)
                        report_mismatch("differing_count", 32'(i_out_data.differing_count),
                                        32'(want.differing_count));
                    if (i_out_data.compared_count !== want.compared_count)
                        report_mismatch("compared_count", 32'(i_out_data.compared_count),
                                        32'(want.compared_count));
                    if (i_out_data.peak_difference !== want.peak_difference)
                        report_mismatch("peak_difference", 32'(i_out_data.peak_difference),
                                        32'(want.peak_difference));
                    if (i_out_data.passed !== want.passed)
                        report_mismatch("passed", 32'(i_out_data.passed), 32'(want.passed));
                end
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_cnt;
        o_frames     <= frame_cnt;
    end

endmodule

### verif/masked_pixel_diff_counter_test.sv
`timescale 1ns / 1ps

module masked_pixel_diff_counter_test;
    import mpdc_pkg::*;

    localparam int         MASK_SLOTS = 8;
    localparam logic [2:0] UNUSED_REG = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_pix_in     i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_pix_out    o_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = CFG_WIDTH;
    logic [63:0] i_cfg_data = '0;

    int mismatches;
    int pending;
    int frames;
    int items_sent = 0;
    int masks_sent = 0;
    bit tx_calm = 1'b0;
    bit rx_hold_req = 1'b0;

    always #6 i_clk = ~i_clk;

    masked_pixel_diff_counter #(.MASKS(MASK_SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    diff_frame_checker #(.MASKS(MASK_SLOTS)) frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_frames     (frames)
    );

    function automatic int idle_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic logic [63:0] pack_rect(int x, int y, int w, int h);
        return {16'(h), 16'(w), 16'(y), 16'(x)};
    endfunction

    function automatic logic [63:0] with_junk(logic [63:0] v, int bits);
        if ($urandom_range(0, 3) != 0) return v;
        return ({$urandom, $urandom} << bits) | v;
    endfunction

    function automatic logic [12:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 13'($urandom_range(1, 8));
        if (r < 88) return 13'($urandom_range(9, 40));
        if (r < 94) return 13'($urandom_range(4096, 8191));
        return '0;
    endfunction

    task automatic push_item(input t_pix_in it);
        int gap;
        gap = idle_gap(tx_calm);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (it.operation == OP_MASK) masks_sent++;
    endtask

    task automatic send_pair(input logic [31:0] actual, input logic [31:0] baseline);
        t_pix_in it;
        it = t_pix_in'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.operation      = OP_PIXEL;
        it.actual_pixel   = actual;
        it.baseline_pixel = baseline;
        push_item(it);
    endtask

    task automatic send_mask(input logic [2:0] slot, input int x, input int y,
                             input int w, input int h);
        t_pix_in it;
        it = t_pix_in'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.operation = OP_MASK;
        it.mask_slot = slot;
        {it.mask_h, it.mask_w, it.mask_y, it.mask_x} = pack_rect(x, y, w, h);
        push_item(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Stop offering, wait out every outstanding result plus the pipeline depth.
    task automatic settle();
        i_valid     <= 1'b0;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int stall;
        int taken;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall = 120;
            end else begin
                stall = idle_gap(calm);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            taken++;
            if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stimulus
        int          phase;
        int          span;
        int          c;
        logic [31:0] base;
        logic [31:0] pix;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x2 frame: mask hit, disabled mask, alpha difference, frame summary
        write_reg(CFG_WIDTH, 64'd3);
        write_reg(CFG_HEIGHT, 64'd2);
        write_reg(CFG_REGION, '0);
        write_reg(CFG_TOLERANCE, '0);
        write_reg(CFG_SKIP_ALPHA, '0);
        write_reg(CFG_THRESHOLD, '0);
        write_reg(UNUSED_REG, '1);
        send_mask(3'd0, 1, 0, 1, 1);
        send_mask(3'd7, -32768, -32768, 0, 32767);
        send_pair(32'hFFFF_FFFF, 32'h0000_0000);
        send_pair(32'h1234_5678, 32'h0BAD_F00D);
        send_pair(32'h8040_2010, 32'h8040_2010);
        send_pair(32'h8000_0000, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h0001_0200, 32'h0000_0000);
        settle();

        // size extremes, region that clamps to nothing, full tolerance, alpha ignored
        write_reg(CFG_WIDTH, '0);
        write_reg(CFG_HEIGHT, 64'h1FFF);
        write_reg(CFG_REGION, pack_rect(-32768, -32768, 32767, 32767));
        write_reg(CFG_TOLERANCE, 64'd255);
        write_reg(CFG_SKIP_ALPHA, 64'd1);
        write_reg(CFG_THRESHOLD, 64'h7FFF);
        send_pair(32'hFF00_0000, 32'h0000_0000);
        send_pair(32'h00FF_FFFF, 32'h0000_0000);
        send_pair(32'h1234_5678, 32'h8765_4321);
        settle();
        // height shrinks mid-frame, so the next pixel closes it
        write_reg(CFG_HEIGHT, 64'd1);
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);
        settle();

        // fully masked single-pixel frames: nothing compared
        write_reg(CFG_THRESHOLD, 64'(FULL_PASS));
        send_mask(3'd0, 0, 0, 32767, 32767);
        send_pair($urandom, $urandom);
        settle();
        write_reg(CFG_THRESHOLD, 64'(FULL_PASS) - 64'd1);
        send_pair($urandom, $urandom);
        send_mask(3'd0, 0, 0, -1, 5);
        settle();

        // compare region inside a 4x2 image, verdict exactly at the threshold
        write_reg(CFG_WIDTH, 64'd4);
        write_reg(CFG_HEIGHT, 64'd2);
        write_reg(CFG_REGION, pack_rect(1, 0, 2, 1));
        write_reg(CFG_TOLERANCE, '0);
        write_reg(CFG_SKIP_ALPHA, '0);
        write_reg(CFG_THRESHOLD, 64'd12800);
        send_pair(32'h0000_00FF, 32'h0000_0000);
        send_pair(32'h0000_0040, 32'h0000_0000);
        send_pair(32'h5555_5555, 32'h5555_5555);
        repeat (5) send_pair($urandom, $urandom);

        for (phase = 0; items_sent < 1224; phase++) begin
            settle();
            if (phase == 0 || $urandom_range(0, 1)) begin
                write_reg(CFG_WIDTH, with_junk(64'(pick_size()), 13));
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
                write_reg(CFG_HEIGHT, with_junk(64'(pick_size()), 13));
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0, 1: write_reg(CFG_REGION, pack_rect($urandom_range(0, 13) - 3,
                                                          $urandom_range(0, 11) - 3,
                                                          $urandom_range(0, 14) - 2,
                                                          $urandom_range(0, 12) - 2));
                    2: write_reg(CFG_REGION, pack_rect($urandom, $urandom,
                                                       -$urandom_range(0, 5), $urandom));
                    3: write_reg(CFG_REGION, {$urandom, $urandom});
                    default: write_reg(CFG_REGION, '0);
                endcase
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: write_reg(CFG_TOLERANCE, with_junk('0, 8));
                    1: write_reg(CFG_TOLERANCE, with_junk(64'd255, 8));
                    2: write_reg(CFG_TOLERANCE, with_junk(64'($urandom_range(0, 30)), 8));
                    default: write_reg(CFG_TOLERANCE,
                                       with_junk(64'($urandom_range(0, 255)), 8));
                endcase
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
                write_reg(CFG_SKIP_ALPHA, with_junk(64'($urandom_range(0, 1)), 1));
            end
            if (phase == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_THRESHOLD, with_junk('0, 15));
                    1: write_reg(CFG_THRESHOLD, with_junk(64'(FULL_PASS), 15));
                    2: write_reg(CFG_THRESHOLD, with_junk(64'(FULL_PASS) - 64'd1, 15));
                    3: write_reg(CFG_THRESHOLD, with_junk(64'h7FFF, 15));
                    default: write_reg(CFG_THRESHOLD,
                                       with_junk(64'($urandom_range(0, 32767)), 15));
                endcase
            end

            tx_calm = ($urandom_range(0, 3) == 0);
            span = $urandom_range(20, 110);
            if (phase == 2) begin
                // back-to-back input while the output side is held off
                tx_calm = 1'b1;
                rx_hold_req = 1'b1;
                span = 150;
            end

            repeat (span) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 9) < 7) begin
                        send_mask(3'($urandom_range(0, 7)), $urandom_range(0, 16) - 4,
                                  $urandom_range(0, 14) - 4, $urandom_range(0, 11) - 3,
                                  $urandom_range(0, 9) - 3);
                    end else begin
                        send_mask(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                                  $urandom);
                    end
                end else begin
                    base = $urandom;
                    case ($urandom_range(0, 3))
                        0: send_pair(base, base);
                        1, 2: begin
                            pix = base;
                            for (c = 0; c < 4; c++) begin
                                if ($urandom_range(0, 1))
                                    pix[8*c +: 8] = pix[8*c +: 8] + 8'($urandom_range(0, 48)) - 8'd24;
                            end
                            send_pair(pix, base);
                        end
                        default: send_pair($urandom, base);
                    endcase
                end
            end
        end

        settle();
        repeat (12) @(posedge i_clk);
        $display("Covered %0d pixel pairs and %0d mask loads over %0d random settings",
                 items_sent - masks_sent, masks_sent, phase);
        $display("plus the directed cases; %0d frame summaries checked.", frames);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
